// ----- src/bls_pkg.sv -----
`default_nettype none

package bls_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 13;
    localparam int COLOR_W    = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_DRAW_RED     = 3'd2;
    localparam t_cfg_idx CFG_DRAW_GREEN   = 3'd3;
    localparam t_cfg_idx CFG_DRAW_BLUE    = 3'd4;

    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd4096;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd4096;
    localparam logic [COLOR_W-1:0] RST_DRAW_RED     = 16'd250;
    localparam logic [COLOR_W-1:0] RST_DRAW_GREEN   = 16'd40;
    localparam logic [COLOR_W-1:0] RST_DRAW_BLUE    = 16'd40;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

endpackage

`default_nettype wire

// ----- src/bls_req_if.sv -----
`default_nettype none

interface bls_req_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (
        output valid, req_type, x_start, y_start, x_end, y_end,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_start, y_start, x_end, y_end,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/bls_pix_if.sv -----
`default_nettype none

interface bls_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic                          pixel_valid;
    logic [COORD_BITS-1:0]         pixel_x;
    logic [COORD_BITS-1:0]         pixel_y;
    logic                          in_image;
    logic                          last_pixel;
    logic [bls_pkg::COLOR_W-1:0]   pixel_red;
    logic [bls_pkg::COLOR_W-1:0]   pixel_green;
    logic [bls_pkg::COLOR_W-1:0]   pixel_blue;

    modport source (
        output valid, pixel_valid, pixel_x, pixel_y, in_image, last_pixel,
               pixel_red, pixel_green, pixel_blue,
        input  ready
    );

    modport sink (
        input  valid, pixel_valid, pixel_x, pixel_y, in_image, last_pixel,
               pixel_red, pixel_green, pixel_blue,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/bls_skid.sv -----
`default_nettype none

module bls_skid #(
    parameter int WIDTH = 75
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid_data;
    logic             in_fire;
    logic             out_fire;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_fire) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire;
                end
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_fire) begin
                r_out_data <= i_data;
            end
        end else if (in_fire) begin
            r_skid_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/bresenham_line_stepper_top.sv -----
// Bresenham line stepper: rasterizes a line between two endpoints, one pixel per item.
// Request channel i_req: an item with req_type start loads both endpoints and yields
// the first pixel; an item with req_type step yields the next pixel of the line.
// Every request item produces exactly one item on the pixel channel o_pix. A step
// with no line in progress yields an item with pixel_valid low and all fields zero.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets image width and
// height and the drawing color; write it only while the block is idle.
// A pixel is computed combinationally and registered in the output buffer. Throughput
// is one item per cycle unless the receiver stalls, set by the single add-and-compare
// that advances the error term and the minor coordinate in the stepping register stage.
// The result goes through a two-entry output buffer (output register plus skid
// register), so i_req.ready depends only on registered state. When the receiver
// stalls, one more item is taken into the skid register and ready then drops
// until the receiver takes an item.
// Reset is synchronous and active low: it drops any line in progress, empties the
// output buffer and restores width 4096, height 4096 and color (250, 40, 40).
`default_nettype none

module bresenham_line_stepper_top #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    bls_req_if.sink                                 i_req,
    bls_pix_if.source                               o_pix,
    input  wire logic                               i_cfg_we,
    input  wire logic [bls_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bls_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int C     = COORD_BITS;
    localparam int E     = COORD_BITS + 3;
    localparam int CMP_W = (COORD_BITS > bls_pkg::DIM_W) ? COORD_BITS : bls_pkg::DIM_W;
    localparam int PW    = 2 * COORD_BITS + 3 + 3 * bls_pkg::COLOR_W;
    localparam logic [C-1:0] ONE = 1;

    // Configuration registers.
    logic [bls_pkg::DIM_W-1:0]   r_width;
    logic [bls_pkg::DIM_W-1:0]   r_height;
    logic [bls_pkg::COLOR_W-1:0] r_red;
    logic [bls_pkg::COLOR_W-1:0] r_green;
    logic [bls_pkg::COLOR_W-1:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bls_pkg::RST_IMAGE_WIDTH;
            r_height <= bls_pkg::RST_IMAGE_HEIGHT;
            r_red    <= bls_pkg::RST_DRAW_RED;
            r_green  <= bls_pkg::RST_DRAW_GREEN;
            r_blue   <= bls_pkg::RST_DRAW_BLUE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bls_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[bls_pkg::DIM_W-1:0];
                bls_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[bls_pkg::DIM_W-1:0];
                bls_pkg::CFG_DRAW_RED:     r_red    <= i_cfg_data;
                bls_pkg::CFG_DRAW_GREEN:   r_green  <= i_cfg_data;
                bls_pkg::CFG_DRAW_BLUE:    r_blue   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Line state.
    logic                r_active;
    logic                r_steep;
    logic [C-1:0]        r_major;
    logic [C-1:0]        r_minor;
    logic [C-1:0]        r_end;
    logic                r_down;
    logic signed [E-1:0] r_err;
    logic [C:0]          r_tmd;
    logic signed [E-1:0] r_tdd;

    logic                n_active;
    logic                n_steep;
    logic [C-1:0]        n_major;
    logic [C-1:0]        n_minor;
    logic [C-1:0]        n_end;
    logic                n_down;
    logic signed [E-1:0] n_err;
    logic [C:0]          n_tmd;
    logic signed [E-1:0] n_tdd;

    // Setup of a new line.
    logic                is_start;
    logic [C-1:0]        adx, ady;
    logic                s_steep;
    logic [C-1:0]        a0r, b0r, a1r, b1r;
    logic                s_swap;
    logic [C-1:0]        a0, b0, a1, b1;
    logic [C-1:0]        da, adb;
    logic                s_down;
    logic signed [E-1:0] s_err, s_tdd;
    logic [C:0]          s_tmd;

    // Current pixel and advance.
    logic                emit;
    logic                c_steep, c_down;
    logic [C-1:0]        c_major, c_minor, c_end;
    logic signed [E-1:0] c_err, c_tdd;
    logic [C:0]          c_tmd;
    logic [C-1:0]        px, py;
    logic                last;
    logic                in_bounds;
    logic                in_fire;

    logic                p_valid;
    logic [C-1:0]        p_x, p_y;
    logic                p_in_image, p_last;
    logic [bls_pkg::COLOR_W-1:0] p_red, p_green, p_blue;
    logic [PW-1:0]       p_data, q_data;
    logic                skid_ready;

    assign is_start = (i_req.req_type == bls_pkg::REQ_START);
    assign in_fire  = i_req.valid && skid_ready;

    always_comb begin
        adx = (i_req.x_end >= i_req.x_start) ? i_req.x_end - i_req.x_start
                                             : i_req.x_start - i_req.x_end;
        ady = (i_req.y_end >= i_req.y_start) ? i_req.y_end - i_req.y_start
                                             : i_req.y_start - i_req.y_end;
        s_steep = !(ady < adx);
        a0r = s_steep ? i_req.y_start : i_req.x_start;
        b0r = s_steep ? i_req.x_start : i_req.y_start;
        a1r = s_steep ? i_req.y_end   : i_req.x_end;
        b1r = s_steep ? i_req.x_end   : i_req.y_end;
        s_swap = a0r > a1r;
        a0 = s_swap ? a1r : a0r;
        b0 = s_swap ? b1r : b0r;
        a1 = s_swap ? a0r : a1r;
        b1 = s_swap ? b0r : b1r;
        da = a1 - a0;
        s_down = b1 < b0;
        adb = s_down ? b0 - b1 : b1 - b0;
        s_tmd = {adb, 1'b0};
        s_tdd = $signed({2'b00, adb, 1'b0}) - $signed({2'b00, da, 1'b0});
        s_err = $signed({2'b00, adb, 1'b0}) - $signed({3'b000, da});
    end

    always_comb begin
        c_steep = is_start ? s_steep : r_steep;
        c_down  = is_start ? s_down  : r_down;
        c_major = is_start ? a0      : r_major;
        c_minor = is_start ? b0      : r_minor;
        c_end   = is_start ? a1      : r_end;
        c_err   = is_start ? s_err   : r_err;
        c_tmd   = is_start ? s_tmd   : r_tmd;
        c_tdd   = is_start ? s_tdd   : r_tdd;
        emit    = is_start || r_active;

        px        = c_steep ? c_minor : c_major;
        py        = c_steep ? c_major : c_minor;
        last      = (c_major == c_end);
        in_bounds = (CMP_W'(px) < CMP_W'(r_width)) && (CMP_W'(py) < CMP_W'(r_height));

        n_active = r_active;
        n_steep  = r_steep;
        n_down   = r_down;
        n_major  = r_major;
        n_minor  = r_minor;
        n_end    = r_end;
        n_err    = r_err;
        n_tmd    = r_tmd;
        n_tdd    = r_tdd;
        if (in_fire && emit) begin
            n_steep  = c_steep;
            n_down   = c_down;
            n_end    = c_end;
            n_tmd    = c_tmd;
            n_tdd    = c_tdd;
            n_major  = c_major;
            n_minor  = c_minor;
            n_err    = c_err;
            n_active = !last;
            if (!last) begin
                n_major = c_major + ONE;
                if (c_err > 0) begin
                    n_minor = c_down ? c_minor - ONE : c_minor + ONE;
                    n_err   = c_err + c_tdd;
                end else begin
                    n_err   = c_err + $signed({2'b00, c_tmd});
                end
            end
        end

        p_valid    = emit;
        p_x        = emit ? px : '0;
        p_y        = emit ? py : '0;
        p_in_image = emit && in_bounds;
        p_last     = emit && last;
        p_red      = emit ? r_red   : '0;
        p_green    = emit ? r_green : '0;
        p_blue     = emit ? r_blue  : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steep <= n_steep;
        r_down  <= n_down;
        r_major <= n_major;
        r_minor <= n_minor;
        r_end   <= n_end;
        r_err   <= n_err;
        r_tmd   <= n_tmd;
        r_tdd   <= n_tdd;
    end

    assign p_data = {p_valid, p_x, p_y, p_in_image, p_last, p_red, p_green, p_blue};

    bls_skid #(
        .WIDTH (PW)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (skid_ready),
        .i_data  (p_data),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_data  (q_data)
    );

    assign i_req.ready = skid_ready;
    assign {o_pix.pixel_valid, o_pix.pixel_x, o_pix.pixel_y, o_pix.in_image,
            o_pix.last_pixel, o_pix.pixel_red, o_pix.pixel_green,
            o_pix.pixel_blue} = q_data;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = 12;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 110;
    localparam int DIR_ROWS       = 27;

    localparam bls_pkg::t_cfg_idx CFG_IDX_TOP = '1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic   req_type;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_line_req;

    typedef struct packed {
        logic                        pixel_valid;
        t_coord                      pixel_x;
        t_coord                      pixel_y;
        logic                        in_image;
        logic                        last_pixel;
        logic [bls_pkg::COLOR_W-1:0] pixel_red;
        logic [bls_pkg::COLOR_W-1:0] pixel_green;
        logic [bls_pkg::COLOR_W-1:0] pixel_blue;
    } t_pixel;

    typedef struct packed {
        t_line_req req;
        logic      given;
        t_pixel    pix;
    } t_dir_row;

    localparam t_coord CMAX  = '1;
    localparam t_pixel BLANK = '0;

    // Rows with given set carry a result that follows directly from the reset state.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{'{bls_pkg::REQ_STEP,  CMAX, CMAX, CMAX, CMAX}, 1'b1, BLANK},
        '{'{bls_pkg::REQ_START, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1,
          '{1'b1, 12'd0, 12'd0, 1'b1, 1'b1, bls_pkg::RST_DRAW_RED,
            bls_pkg::RST_DRAW_GREEN, bls_pkg::RST_DRAW_BLUE}},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, BLANK},
        '{'{bls_pkg::REQ_START, CMAX, CMAX, CMAX, CMAX}, 1'b1,
          '{1'b1, CMAX, CMAX, 1'b1, 1'b1, bls_pkg::RST_DRAW_RED,
            bls_pkg::RST_DRAW_GREEN, bls_pkg::RST_DRAW_BLUE}},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, BLANK},
        '{'{bls_pkg::REQ_START, 12'd0, 12'd0, CMAX, CMAX}, 1'b1,
          '{1'b1, 12'd0, 12'd0, 1'b1, 1'b0, bls_pkg::RST_DRAW_RED,
            bls_pkg::RST_DRAW_GREEN, bls_pkg::RST_DRAW_BLUE}},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_START, CMAX, 12'd0, 12'd0, CMAX}, 1'b1,
          '{1'b1, CMAX, 12'd0, 1'b1, 1'b0, bls_pkg::RST_DRAW_RED,
            bls_pkg::RST_DRAW_GREEN, bls_pkg::RST_DRAW_BLUE}},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_START, 12'd10, 12'd5, 12'd0, 12'd5}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_START, 12'd7, 12'd20, 12'd7, 12'd3}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_START, 12'd3, 12'd9, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_START, 12'd0, 12'd3, 12'd9, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_START, 12'd2, 12'd0, 12'd0, 12'd1}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK},
        '{'{bls_pkg::REQ_STEP,  12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, BLANK}
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    bls_pkg::t_cfg_idx              i_cfg_idx;
    logic [bls_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           r_rx_ready = 1'b0;

    bls_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    bls_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

    assign pix_ch.ready = r_rx_ready;

    bresenham_line_stepper_top #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_pix      (pix_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [bls_pkg::DIM_W-1:0]   img_w;
    logic [bls_pkg::DIM_W-1:0]   img_h;
    logic [bls_pkg::COLOR_W-1:0] ink_r;
    logic [bls_pkg::COLOR_W-1:0] ink_g;
    logic [bls_pkg::COLOR_W-1:0] ink_b;

    logic   ln_active;
    logic   ln_steep;
    logic   ln_down;
    t_coord ln_major;
    t_coord ln_minor;
    t_coord ln_major_end;
    int     ln_err;
    int     ln_twice_minor;
    int     ln_twice_diff;

    t_pixel      expected_pixels [$];
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_stall_pct = 0;
    int          errors       = 0;
    int          idle_cycles  = 0;
    int          items_sent   = 0;
    int          lines_started = 0;
    int          pixels_seen  = 0;
    int          blanks_seen  = 0;

    function automatic t_pixel rasterize(input t_line_req r);
        t_pixel p;
        int     x0, y0, x1, y1, a0, b0, a1, b1, dmaj, dmin, t, adx, ady;
        p = '0;
        if (r.req_type == bls_pkg::REQ_START) begin
            x0  = int'(r.x_start);
            y0  = int'(r.y_start);
            x1  = int'(r.x_end);
            y1  = int'(r.y_end);
            adx = (x1 > x0) ? x1 - x0 : x0 - x1;
            ady = (y1 > y0) ? y1 - y0 : y0 - y1;
            ln_steep = !(ady < adx);
            if (ln_steep) begin
                a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end else begin
                a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
            if (a0 > a1) begin
                t = a0; a0 = a1; a1 = t;
                t = b0; b0 = b1; b1 = t;
            end
            dmaj    = a1 - a0;
            dmin    = b1 - b0;
            ln_down = dmin < 0;
            if (dmin < 0) begin
                dmin = -dmin;
            end
            ln_major       = t_coord'(a0);
            ln_minor       = t_coord'(b0);
            ln_major_end   = t_coord'(a1);
            ln_twice_minor = 2 * dmin;
            ln_twice_diff  = 2 * (dmin - dmaj);
            ln_err         = 2 * dmin - dmaj;
            ln_active      = 1'b1;
        end else if (!ln_active) begin
            return p;
        end
        p.pixel_valid = 1'b1;
        p.pixel_x     = ln_steep ? ln_minor : ln_major;
        p.pixel_y     = ln_steep ? ln_major : ln_minor;
        p.in_image    = (bls_pkg::DIM_W'(p.pixel_x) < img_w)
                        && (bls_pkg::DIM_W'(p.pixel_y) < img_h);
        p.last_pixel  = (ln_major == ln_major_end);
        p.pixel_red   = ink_r;
        p.pixel_green = ink_g;
        p.pixel_blue  = ink_b;
        if (p.last_pixel) begin
            ln_active = 1'b0;
        end else begin
            if (ln_err > 0) begin
                ln_minor = ln_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
                ln_err   = ln_err + ln_twice_diff;
            end else begin
                ln_err = ln_err + ln_twice_minor;
            end
            ln_major = ln_major + 1'b1;
        end
        return p;
    endfunction

    function automatic string show(input t_pixel p);
        return $sformatf("valid=%0b x=%0d y=%0d in_image=%0b last=%0b rgb=%0h/%0h/%0h",
                         p.pixel_valid, p.pixel_x, p.pixel_y, p.in_image, p.last_pixel,
                         p.pixel_red, p.pixel_green, p.pixel_blue);
    endfunction

    function automatic int any_coord();
        return ($urandom_range(1) == 0) ? int'($urandom_range(80))
                                        : int'($urandom_range(COORD_MAX));
    endfunction

    function automatic int near(input int c, input int span);
        int v;
        v = c + int'($urandom_range(2 * span)) - span;
        if (v < 0) begin
            v = 0;
        end
        if (v > COORD_MAX) begin
            v = COORD_MAX;
        end
        return v;
    endfunction

    function automatic t_line_req noise_step();
        t_line_req r;
        r.req_type = bls_pkg::REQ_STEP;
        r.x_start  = t_coord'($urandom);
        r.y_start  = t_coord'($urandom);
        r.x_end    = t_coord'($urandom);
        r.y_end    = t_coord'($urandom);
        return r;
    endfunction

    task automatic send_req(input t_line_req r, input logic given, input t_pixel given_pix);
        t_pixel p;
        while ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.req_type;
        req_ch.x_start  <= r.x_start;
        req_ch.y_start  <= r.y_start;
        req_ch.x_end    <= r.x_end;
        req_ch.y_end    <= r.y_end;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        p = rasterize(r);
        expected_pixels.push_back(given ? given_pix : p);
        items_sent++;
        if (r.req_type == bls_pkg::REQ_START) begin
            lines_started++;
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_pixels.size() != 0);
    endtask

    task automatic write_reg(input bls_pkg::t_cfg_idx idx,
                             input logic [bls_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            bls_pkg::CFG_IMAGE_WIDTH:  img_w = bls_pkg::DIM_W'(data);
            bls_pkg::CFG_IMAGE_HEIGHT: img_h = bls_pkg::DIM_W'(data);
            bls_pkg::CFG_DRAW_RED:     ink_r = data;
            bls_pkg::CFG_DRAW_GREEN:   ink_g = data;
            bls_pkg::CFG_DRAW_BLUE:    ink_b = data;
            default: ;
        endcase
    endtask

    // Mostly complete lines, some cut short by a new start, and a few bare steps.
    task automatic random_lines(input int count);
        t_line_req r;
        int        sent, kind, span, len, steps, x0, y0, x1, y1;
        sent = 0;
        while (sent < count) begin
            kind = int'($urandom_range(99));
            if (kind < 90) begin
                span = ($urandom_range(99) < 2) ? 200 : 20;
                x0   = any_coord();
                y0   = any_coord();
                x1   = near(x0, span);
                y1   = near(y0, span);
                len  = (x1 > x0) ? x1 - x0 : x0 - x1;
                if (((y1 > y0) ? y1 - y0 : y0 - y1) > len) begin
                    len = (y1 > y0) ? y1 - y0 : y0 - y1;
                end
                if (kind < 75 || len == 0) begin
                    steps = len;
                end else begin
                    steps = int'($urandom_range(len - 1));
                end
                r.req_type = bls_pkg::REQ_START;
                r.x_start  = t_coord'(x0);
                r.y_start  = t_coord'(y0);
                r.x_end    = t_coord'(x1);
                r.y_end    = t_coord'(y1);
                send_req(r, 1'b0, BLANK);
            end else begin
                steps = int'($urandom_range(1, 3)) - 1;
                send_req(noise_step(), 1'b0, BLANK);
            end
            repeat (steps) begin
                send_req(noise_step(), 1'b0, BLANK);
            end
            sent = sent + 1 + steps;
        end
    endtask

    always @(posedge i_clk) begin
        r_rx_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin : pixel_check
        t_pixel got;
        t_pixel want;
        if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            got.pixel_valid = pix_ch.pixel_valid;
            got.pixel_x     = pix_ch.pixel_x;
            got.pixel_y     = pix_ch.pixel_y;
            got.in_image    = pix_ch.in_image;
            got.last_pixel  = pix_ch.last_pixel;
            got.pixel_red   = pix_ch.pixel_red;
            got.pixel_green = pix_ch.pixel_green;
            got.pixel_blue  = pix_ch.pixel_blue;
            if (got.pixel_valid) begin
                pixels_seen++;
            end else begin
                blanks_seen++;
            end
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel item with none expected: %s", $time, show(got));
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: pixel mismatch: expected %s, actual %s",
                             $time, show(want), show(got));
                end
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        logic [bls_pkg::CFG_DATA_W-1:0] w, h, r, g, b;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= bls_pkg::REQ_START;
        req_ch.x_start  <= '0;
        req_ch.y_start  <= '0;
        req_ch.x_end    <= '0;
        req_ch.y_end    <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= bls_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;

        img_w          = bls_pkg::RST_IMAGE_WIDTH;
        img_h          = bls_pkg::RST_IMAGE_HEIGHT;
        ink_r          = bls_pkg::RST_DRAW_RED;
        ink_g          = bls_pkg::RST_DRAW_GREEN;
        ink_b          = bls_pkg::RST_DRAW_BLUE;
        ln_active      = 1'b0;
        ln_steep       = 1'b0;
        ln_down        = 1'b0;
        ln_major       = '0;
        ln_minor       = '0;
        ln_major_end   = '0;
        ln_err         = 0;
        ln_twice_minor = 0;
        ln_twice_diff  = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            send_req(DIR_TABLE[k].req, DIR_TABLE[k].given, DIR_TABLE[k].pix);
        end
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            r = 16'($urandom);
            g = 16'($urandom);
            b = 16'($urandom);
            case (ph)
                0: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                    w = '0; h = '0; r = '0; g = '0; b = '0;
                end
                1: begin
                    // Width and height take all ones, so the upper data bits must be dropped.
                    sender_idle_pct = 86; receiver_stall_pct = 0;
                    w = '1; h = '1; r = '1; g = '1; b = '1;
                end
                2: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 86;
                    w = 16'($urandom_range(1, 64));
                    h = 16'($urandom_range(1, 64));
                end
                3: begin
                    sender_idle_pct = 7;  receiver_stall_pct = 7;
                    w = 16'(bls_pkg::RST_IMAGE_WIDTH);
                    h = 16'(bls_pkg::RST_IMAGE_HEIGHT);
                end
                default: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                    w = 16'($urandom_range(0, 4096));
                    h = 16'($urandom_range(0, 4096));
                end
            endcase
            write_reg(bls_pkg::CFG_IMAGE_WIDTH, w);
            write_reg(bls_pkg::CFG_IMAGE_HEIGHT, h);
            write_reg(bls_pkg::CFG_DRAW_RED, r);
            write_reg(bls_pkg::CFG_DRAW_GREEN, g);
            write_reg(bls_pkg::CFG_DRAW_BLUE, b);
            if (ph == PHASES - 1) begin
                write_reg(bls_pkg::t_cfg_idx'($urandom_range(bls_pkg::CFG_DRAW_BLUE + 1,
                                                             CFG_IDX_TOP)),
                          16'($urandom));
            end
            i_cfg_we <= 1'b0;
            random_lines(PHASE_ITEMS);
            drain();
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d request items, %0d lines started, %0d pixels, %0d blank results",
                 items_sent, lines_started, pixels_seen, blanks_seen);
        $display("tb_top: %0d register settings, sender and receiver idling varied per setting",
                 PHASES + 1);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
